// ===== design/slipcrc_pkg.sv =====
package slipcrc_pkg;

    localparam logic [7:0] END_CODE     = 8'hC0;
    localparam logic [7:0] ESC_CODE     = 8'hDB;
    localparam logic [7:0] ESC_END_CODE = 8'hDC;
    localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

    localparam int unsigned MIN_FRAME   = 8;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // Status of one finished frame, as it leaves on the result channel
    typedef struct packed {
        logic [7:0]  frame_len;
        logic        crc_ok;
        logic [15:0] command_word;
        logic [31:0] value_word;
    } frame_status_t;

    // CRC-16/CCITT, MSB first, one byte folded in
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/slip_deframer_crc_check.sv =====
// SLIP deframer with CRC-16/CCITT check.
//
// Input channel (in_valid / in_ready / rx_byte): one raw SLIP-encoded byte
// per beat. Output channel (out_valid / out_ready / frame_len, crc_ok,
// command_word, value_word): one status beat for every END byte that closes
// a frame of at least 8 decoded bytes; shorter frames and repeated END
// bytes yield nothing.
//
// Throughput is one byte per cycle: the byte lands in an input register, the
// escape, header capture and byte-wide CRC update sit between that register
// and the state/result registers, so a new byte is taken every cycle unless
// a result waits behind a full output register. An accepted END beat waits in
// the input register, then its status is registered with out_valid set.
//
// When the receiver stalls, the finished status waits in the output register
// and bytes keep flowing in; only a second END with a result behind a full
// output register holds the input register and drops in_ready.
// Reset clears the escape flag, length, CRC, delay bytes and both valids.
module slip_deframer_crc_check #(
    parameter int unsigned BUF_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_len,
    output logic        crc_ok,
    output logic [15:0] command_word,
    output logic [31:0] value_word
);
    import slipcrc_pkg::*;

    logic          stage_valid_reg, stage_valid_next;
    logic [7:0]    stage_byte_reg;
    logic          out_valid_reg,   out_valid_next;
    frame_status_t out_reg;

    logic          stage_go;
    logic          out_free;
    logic          res_valid;
    frame_status_t res;

    // Output register frees up this cycle if empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    // Advance the stage unless it carries a result with nowhere to go
    assign stage_go = stage_valid_reg && (!res_valid || out_free);
    assign in_ready = !stage_valid_reg || stage_go;

    slipcrc_decode #(
        .BUF_BYTES(BUF_BYTES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (stage_go),
        .rx_byte     (stage_byte_reg),
        .result_valid(res_valid),
        .result      (res)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_ready)
        begin
            stage_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (stage_go && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: capture byte on accept, status on result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= rx_byte;
        end
        if (stage_go && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_len    = out_reg.frame_len;
    assign crc_ok       = out_reg.crc_ok;
    assign command_word = out_reg.command_word;
    assign value_word   = out_reg.value_word;

    // An empty output register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    // A held stage keeps its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_go |=> stage_valid_reg && $stable(stage_byte_reg))
        else $error("stage byte lost while blocked");

    // Only an END byte produces a status beat
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && res_valid |-> stage_byte_reg == END_CODE)
        else $error("status produced by a non-END byte");

    // A new status only loads into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && res_valid |-> out_free)
        else $error("status overwrote a pending beat");

endmodule

// ===== design/slipcrc_decode.sv =====
module slipcrc_decode #(
    parameter int unsigned BUF_BYTES = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [7:0]                 rx_byte,
    output logic                       result_valid,
    output slipcrc_pkg::frame_status_t result
);
    import slipcrc_pkg::*;

    localparam int unsigned CW = $clog2(BUF_BYTES + 1);

    logic          escape_reg,  escape_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [15:0]   crc_reg,     crc_next;
    logic [7:0]    newest_reg,  newest_next;
    logic [7:0]    older_reg,   older_next;
    logic [15:0]   command_reg, command_next;
    logic [31:0]   value_reg,   value_next;

    logic [7:0]    data_byte;
    logic          is_end;
    logic          is_esc;
    logic          long_enough;

    assign is_end      = (rx_byte == END_CODE);
    assign is_esc      = (rx_byte == ESC_CODE);
    assign long_enough = (count_reg >= CW'(MIN_FRAME));

    // Undo the escape on the byte after ESC; unknown codes pass unchanged
    always_comb
    begin
        data_byte = rx_byte;
        if (escape_reg)
        begin
            if (rx_byte == ESC_END_CODE)
            begin
                data_byte = END_CODE;
            end
            else if (rx_byte == ESC_ESC_CODE)
            begin
                data_byte = ESC_CODE;
            end
        end
    end

    assign result_valid        = is_end && long_enough;
    assign result.frame_len    = 8'(count_reg);
    assign result.crc_ok       = (crc_reg == {newest_reg, older_reg});
    assign result.command_word = command_reg;
    assign result.value_word   = value_reg;

    always_comb
    begin
        escape_next  = escape_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        newest_next  = newest_reg;
        older_next   = older_reg;
        command_next = command_reg;
        value_next   = value_reg;
        if (is_esc)
        begin
            escape_next = 1'b1;
        end
        else if (is_end)
        begin
            // close the frame and restart
            escape_next = 1'b0;
            count_next  = '0;
            crc_next    = '0;
            newest_next = '0;
            older_next  = '0;
        end
        else
        begin
            escape_next = 1'b0;
            if (count_reg == CW'(BUF_BYTES))
            begin
                // overflow: drop the byte and start a new frame
                count_next  = '0;
                crc_next    = '0;
                newest_next = '0;
                older_next  = '0;
            end
            else
            begin
                if (count_reg >= CW'(2))
                begin
                    crc_next = crc16_byte(crc_reg, older_reg);
                end
                older_next  = newest_reg;
                newest_next = data_byte;
                if (count_reg == CW'(0)) command_next[7:0]  = data_byte;
                if (count_reg == CW'(1)) command_next[15:8] = data_byte;
                if (count_reg == CW'(4)) value_next[7:0]    = data_byte;
                if (count_reg == CW'(5)) value_next[15:8]   = data_byte;
                if (count_reg == CW'(6)) value_next[23:16]  = data_byte;
                if (count_reg == CW'(7)) value_next[31:24]  = data_byte;
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= 1'b0;
            count_reg   <= '0;
            crc_reg     <= '0;
            newest_reg  <= '0;
            older_reg   <= '0;
            command_reg <= '0;
            value_reg   <= '0;
        end
        else if (advance)
        begin
            escape_reg  <= escape_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            newest_reg  <= newest_next;
            older_reg   <= older_next;
            command_reg <= command_next;
            value_reg   <= value_next;
        end
    end

endmodule

// ===== tb/sv/slip_frame_monitor.sv =====
`timescale 1ns / 1ps

// Watches both channels of the SLIP deframer, predicts the status beat that
// each closing END produces, and compares it with what comes out.
module slip_frame_monitor #(
    parameter int unsigned BUF_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_len,
    input  logic        crc_ok,
    input  logic [15:0] command_word,
    input  logic [31:0] value_word,
    output int          fail_count,
    output int          pending_status,
    output int          status_checked,
    output int          crc_match_seen
);
    import slipcrc_pkg::*;

    frame_status_t expected_status[$];
    frame_status_t want;
    frame_status_t got;

    logic        esc_armed;
    int          frame_bytes;
    logic [15:0] crc_acc;
    logic [7:0]  newest_byte;
    logic [7:0]  prior_byte;
    logic [15:0] cmd_acc;
    logic [31:0] val_acc;
    logic [7:0]  decoded;

    // CRC-16/CCITT, one message bit at a time
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
                     exp_v, act_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_status.delete();
            esc_armed      = 1'b0;
            frame_bytes    = 0;
            crc_acc        = '0;
            newest_byte    = '0;
            prior_byte     = '0;
            cmd_acc        = '0;
            val_acc        = '0;
            fail_count     = 0;
            status_checked = 0;
            crc_match_seen = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decoded = rx_byte;
                if (decoded == ESC_CODE)
                begin
                    esc_armed = 1'b1;
                end
                else if (decoded == END_CODE)
                begin
                    if (frame_bytes >= MIN_FRAME)
                    begin
                        want.frame_len    = 8'(frame_bytes);
                        want.crc_ok       = (crc_acc == {newest_byte, prior_byte});
                        want.command_word = cmd_acc;
                        want.value_word   = val_acc;
                        expected_status.push_back(want);
                    end
                    esc_armed   = 1'b0;
                    frame_bytes = 0;
                    crc_acc     = '0;
                    newest_byte = '0;
                    prior_byte  = '0;
                end
                else
                begin
                    if (esc_armed)
                    begin
                        if (decoded == ESC_END_CODE)
                            decoded = END_CODE;
                        else if (decoded == ESC_ESC_CODE)
                            decoded = ESC_CODE;
                        esc_armed = 1'b0;
                    end
                    if (frame_bytes >= BUF_BYTES)
                    begin
                        // drop the byte and start over as a fresh frame
                        frame_bytes = 0;
                        crc_acc     = '0;
                        newest_byte = '0;
                        prior_byte  = '0;
                    end
                    else
                    begin
                        if (frame_bytes >= 2)
                            crc_acc = crc_fold(crc_acc, prior_byte);
                        prior_byte  = newest_byte;
                        newest_byte = decoded;
                        case (frame_bytes)
                            0: cmd_acc[7:0]   = decoded;
                            1: cmd_acc[15:8]  = decoded;
                            4: val_acc[7:0]   = decoded;
                            5: val_acc[15:8]  = decoded;
                            6: val_acc[23:16] = decoded;
                            7: val_acc[31:24] = decoded;
                            default: ;
                        endcase
                        frame_bytes++;
                    end
                end
            end

            if (out_valid && out_ready)
            begin
                got.frame_len    = frame_len;
                got.crc_ok       = crc_ok;
                got.command_word = command_word;
                got.value_word   = value_word;
                if (expected_status.size() == 0)
                begin
                    $display("%0t: status beat with none expected, actual len %0d crc_ok %0b",
                             $time, frame_len, crc_ok);
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (field_differs("frame_len", 32'(want.frame_len),
                                      32'(got.frame_len)) |
                        field_differs("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok)) |
                        field_differs("command_word", 32'(want.command_word),
                                      32'(got.command_word)) |
                        field_differs("value_word", want.value_word, got.value_word))
                        fail_count++;
                    status_checked++;
                    if (want.crc_ok)
                        crc_match_seen++;
                end
            end
        end
        pending_status = expected_status.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the SLIP deframer. Prediction and comparison
// live in slip_frame_monitor beside the block.
module tb_top;
    import slipcrc_pkg::*;

    localparam int unsigned BUF_BYTES    = 128;
    localparam int          TARGET_BYTES = 1900;
    localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int          QUIET_LIMIT  = 5000;  // cycles with no beat on either side
    localparam int          DRAIN_CYCLES = 16;    // status follows END through the input and output registers

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_len;
    logic        crc_ok;
    logic [15:0] command_word;
    logic [31:0] value_word;

    int fail_count;
    int pending_status;
    int status_checked;
    int crc_match_seen;

    int sent_bytes;
    int frame_idx;
    int quiet_cycles;
    bit calm;        // when set, neither side idles
    bit hold_req;    // asks the receiver for its long hold-off

    slip_deframer_crc_check #(
        .BUF_BYTES(BUF_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_len   (frame_len),
        .crc_ok      (crc_ok),
        .command_word(command_word),
        .value_word  (value_word)
    );

    slip_frame_monitor #(
        .BUF_BYTES(BUF_BYTES)
    ) i_frame_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_len     (frame_len),
        .crc_ok        (crc_ok),
        .command_word  (command_word),
        .value_word    (value_word),
        .fail_count    (fail_count),
        .pending_status(pending_status),
        .status_checked(status_checked),
        .crc_match_seen(crc_match_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: end the run when neither channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("FAIL slip_deframer_crc_check");
                $finish;
            end
        end
    end

    // Receiver: random stalls, none while calm, and one long hold-off on
    // request so the output register fills and the block backs up its input.
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Offer one raw byte and hold it until the block takes the beat.
    task automatic put_byte(input logic [7:0] b);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Send one decoded data byte, escaping END and ESC on the wire.
    task automatic put_data(input logic [7:0] b);
        if (b == END_CODE)
        begin
            put_byte(ESC_CODE);
            put_byte(ESC_END_CODE);
        end
        else if (b == ESC_CODE)
        begin
            put_byte(ESC_CODE);
            put_byte(ESC_ESC_CODE);
        end
        else
        begin
            put_byte(b);
        end
    endtask

    // Lean toward the framing codes and the all-zero / all-one bytes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return END_CODE;
            1:       return ESC_CODE;
            2:       return ESC_END_CODE;
            3:       return ESC_ESC_CODE;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send a well-formed frame: payload, CRC low byte then high byte, END.
    // Flip one CRC bit when asked so the check has to fail.
    task automatic send_frame(input int n_payload, input bit bad_crc);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = '0;
        for (int i = 0; i < n_payload; i++)
        begin
            b   = pick_byte();
            crc = crc16_byte(crc, b);
            put_data(b);
        end
        if (bad_crc)
            crc ^= 16'(1) << $urandom_range(0, 15);
        put_data(crc[7:0]);
        put_data(crc[15:8]);
        put_byte(END_CODE);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        sent_bytes = 0;
        frame_idx  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty frames: back-to-back END
        put_byte(END_CODE);
        put_byte(END_CODE);
        // Short frame: three bytes then END, no status
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h7E);
        put_byte(END_CODE);
        // Eight-byte frame touching every escape path
        put_byte(ESC_CODE);
        put_byte(ESC_END_CODE);          // decodes to END value
        put_byte(ESC_CODE);
        put_byte(ESC_ESC_CODE);          // decodes to ESC value
        put_byte(ESC_CODE);
        put_byte(ESC_CODE);              // second ESC keeps the escape armed
        put_byte(ESC_END_CODE);
        put_byte(ESC_CODE);
        put_byte(8'h41);                 // unknown escape, stored as is
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h12);
        put_byte(8'h34);
        put_byte(END_CODE);

        // Random part: mostly well-formed frames, some noise and broken ones
        put_byte(END_CODE);
        while (sent_bytes < TARGET_BYTES)
        begin
            frame_idx++;
            calm = (frame_idx >= 40) && (frame_idx < 80);
            if (frame_idx == 15)
                hold_req = 1'b1;
            case ($urandom_range(0, 19))
                0:
                begin
                    repeat ($urandom_range(1, 8))
                        put_byte(8'($urandom_range(0, 255)));
                    put_byte(END_CODE);
                end
                1: send_frame($urandom_range(0, 5), 1'b0);
                2: put_byte(END_CODE);
                3:
                begin
                    // escape cut off by END, then a normal frame
                    put_byte(ESC_CODE);
                    put_byte(END_CODE);
                    send_frame($urandom_range(6, 20), 1'b0);
                end
                4:
                begin
                    // full-size frame, one past the limit, or a random length that may overflow
                    case ($urandom_range(0, 2))
                        0:       send_frame(int'(BUF_BYTES) - 2, 1'b0);
                        1:       send_frame(int'(BUF_BYTES) - 1, 1'b0);
                        default: send_frame($urandom_range(100, 140), 1'b0);
                    endcase
                end
                5, 6: send_frame($urandom_range(6, 24), 1'b1);
                default: send_frame($urandom_range(6, 24), 1'b0);
            endcase
        end
        in_valid <= 1'b0;

        // Drain: let every predicted status arrive, then settle.
        @(posedge clk);
        while (pending_status != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d random frames, with stalls on both sides",
                 sent_bytes, frame_idx);
        $display("Checked %0d status beats, %0d with good CRC",
                 status_checked, crc_match_seen);
        if (fail_count == 0 && pending_status == 0)
            $display("PASS slip_deframer_crc_check");
        else
            $display("FAIL slip_deframer_crc_check");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/slipcrc_pkg.sv
design/slipcrc_decode.sv
design/slip_deframer_crc_check.sv
tb/sv/slip_frame_monitor.sv
tb/sv/tb_top.sv
